>>> rtl/c8_pkg.sv
// ----------------------------------------------------------------------------
// c8_pkg
// shared constants, codes and types of the interpreter cpu core
// ----------------------------------------------------------------------------
package c8_pkg;

    // memory and screen geometry
    localparam int ADDR_W      = 12;
    localparam int MEM_DEPTH   = 4096;
    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W      = $clog2(STACK_DEPTH);
    localparam int SCREEN_W    = 64;
    localparam int SCREEN_H    = 32;
    localparam int ROW_W       = $clog2(SCREEN_H);
    localparam int COL_W       = $clog2(SCREEN_W);
    localparam logic [ADDR_W-1:0] ENTRY_ADDR = 12'd512;

    // bcd digit weights
    localparam logic [7:0] BCD_HUNDRED = 8'd100;
    localparam logic [7:0] BCD_TEN     = 8'd10;

    // input command codes
    localparam logic [2:0] CMD_STEP  = 3'd0;
    localparam logic [2:0] CMD_FRAME = 3'd1;
    localparam logic [2:0] CMD_KEYDN = 3'd2;
    localparam logic [2:0] CMD_KEYUP = 3'd3;
    localparam logic [2:0] CMD_WRMEM = 3'd4;
    localparam logic [2:0] CMD_PIXEL = 3'd5;

    // result status codes
    localparam logic [2:0] STAT_EXEC     = 3'd0;
    localparam logic [2:0] STAT_WAIT_KEY = 3'd1;
    localparam logic [2:0] STAT_WAIT_DSP = 3'd2;
    localparam logic [2:0] STAT_FAULT    = 3'd3;
    localparam logic [2:0] STAT_OTHER    = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_KEEP_FLAG  = 3'd0;
    localparam logic [2:0] CFG_SHIFT_VX   = 3'd1;
    localparam logic [2:0] CFG_JUMP_VX    = 3'd2;
    localparam logic [2:0] CFG_WRAP_LIN   = 3'd3;
    localparam logic [2:0] CFG_NO_DSPWAIT = 3'd4;
    localparam logic [2:0] CFG_IDX_KEEP   = 3'd5;

    // opcode groups, top nibble of the instruction word
    localparam logic [3:0] OPG_SYS  = 4'h0;
    localparam logic [3:0] OPG_JP   = 4'h1;
    localparam logic [3:0] OPG_CALL = 4'h2;
    localparam logic [3:0] OPG_SE   = 4'h3;
    localparam logic [3:0] OPG_SNE  = 4'h4;
    localparam logic [3:0] OPG_SER  = 4'h5;
    localparam logic [3:0] OPG_LD   = 4'h6;
    localparam logic [3:0] OPG_ADD  = 4'h7;
    localparam logic [3:0] OPG_ALU  = 4'h8;
    localparam logic [3:0] OPG_SNER = 4'h9;
    localparam logic [3:0] OPG_LDI  = 4'hA;
    localparam logic [3:0] OPG_JPV  = 4'hB;
    localparam logic [3:0] OPG_RND  = 4'hC;
    localparam logic [3:0] OPG_DRW  = 4'hD;
    localparam logic [3:0] OPG_KEY  = 4'hE;
    localparam logic [3:0] OPG_MISC = 4'hF;

    // system group low 12 bits
    localparam logic [11:0] OPS_CLS = 12'h0E0;
    localparam logic [11:0] OPS_RET = 12'h0EE;

    // key group low byte
    localparam logic [7:0] OPK_SKP  = 8'h9E;
    localparam logic [7:0] OPK_SKNP = 8'hA1;

    // misc group low byte
    localparam logic [7:0] OPF_GET_DT   = 8'h07;
    localparam logic [7:0] OPF_WAIT_KEY = 8'h0A;
    localparam logic [7:0] OPF_SET_DT   = 8'h15;
    localparam logic [7:0] OPF_SET_ST   = 8'h18;
    localparam logic [7:0] OPF_ADD_I    = 8'h1E;
    localparam logic [7:0] OPF_FONT     = 8'h29;
    localparam logic [7:0] OPF_BCD      = 8'h33;
    localparam logic [7:0] OPF_STORE    = 8'h55;
    localparam logic [7:0] OPF_LOAD     = 8'h65;

    // arithmetic group sub-op codes
    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    // alu result bundle
    typedef struct packed {
        logic [7:0] value;
        logic       flag;
        logic       set_vf;
        logic       legal;
    } alu_res_t;

endpackage

>>> rtl/c8_alu.sv
// ----------------------------------------------------------------------------
// c8_alu
// shared 8-bit arithmetic, logic and shift unit for the register ops
// ----------------------------------------------------------------------------
module c8_alu
(
    input  logic [3:0]       op,
    input  logic [7:0]       vx,
    input  logic [7:0]       vy,
    input  logic             keep_flag,
    input  logic             shift_vx,
    output c8_pkg::alu_res_t res
);

    logic [8:0] sum;
    logic [7:0] src;

    assign sum = {1'b0, vx} + {1'b0, vy};
    assign src = shift_vx ? vx : vy;

    // op decode
    always_comb
    begin
        res.value  = vy;
        res.flag   = 1'b0;
        res.set_vf = 1'b0;
        res.legal  = 1'b1;
        case (op)
            c8_pkg::ALU_MOV:
            begin
                res.value = vy;
            end
            c8_pkg::ALU_OR:
            begin
                res.value  = vx | vy;
                res.set_vf = !keep_flag;
            end
            c8_pkg::ALU_AND:
            begin
                res.value  = vx & vy;
                res.set_vf = !keep_flag;
            end
            c8_pkg::ALU_XOR:
            begin
                res.value  = vx ^ vy;
                res.set_vf = !keep_flag;
            end
            c8_pkg::ALU_ADD:
            begin
                res.value  = sum[7:0];
                res.flag   = sum[8];
                res.set_vf = 1'b1;
            end
            c8_pkg::ALU_SUB:
            begin
                res.value  = vx - vy;
                res.flag   = (vx >= vy);
                res.set_vf = 1'b1;
            end
            c8_pkg::ALU_SHR:
            begin
                res.value  = {1'b0, src[7:1]};
                res.flag   = src[0];
                res.set_vf = 1'b1;
            end
            c8_pkg::ALU_SBN:
            begin
                res.value  = vy - vx;
                res.flag   = (vy >= vx);
                res.set_vf = 1'b1;
            end
            c8_pkg::ALU_SHL:
            begin
                res.value  = {src[6:0], 1'b0};
                res.flag   = src[7];
                res.set_vf = 1'b1;
            end
            default:
            begin
                res.legal = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/chip8_cpu_core.sv
// ----------------------------------------------------------------------------
// chip8_cpu_core
// interpreter cpu with 4 KiB memory, 64x32 xor screen, timers and keypad
// ----------------------------------------------------------------------------
// usage
//   input beats (s_*): s_tuser holds the command, s_tdata the key, address,
//   write byte and random byte. one result beat (m_*) leaves per input beat.
//   cfg_valid/cfg_index/cfg_data write the one-bit quirk registers; always
//   ready, write only while the core is idle.
// sequencing
//   the core takes one beat at a time and is not ready while it works.
//   non-step commands go straight to the result. a step fetches (F1, F2),
//   reads operands (RX, RY) and executes, then writes VF when needed; FX55
//   stores registers one by one, FX65 reads then writes each register, FX33
//   subtracts then writes the digits, a draw does one pixel per cycle.
// reset
//   rst_n clears all control state, then a clearing pass writes zero over
//   the 4096-byte memory, one byte a cycle, with s_tready low.
//   the screen is cleared at once through per-row valid bits.
// stalls
//   a finished result waits in the output register while m_tready is low;
//   the next beat is still taken and its result waits in the core.
// ----------------------------------------------------------------------------
module chip8_cpu_core
(
    input  logic        clk,
    input  logic        rst_n,
    // fields from bit 0: key[3:0], addr[15:4], wdata[23:16], random_byte[31:24]
    input  logic [31:0] s_tdata,
    // fields from bit 0: cmd[2:0]
    input  logic [2:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // fields from bit 0: pixel[0], pc_now[12:1], sound_on[13], screen_changed[14]
    output logic [15:0] m_tdata,
    // fields from bit 0: status[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic        cfg_data
);

    localparam int AW = c8_pkg::ADDR_W;

    // sequencer states
    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_F1    = 5'd2;
    localparam logic [4:0] S_F2    = 5'd3;
    localparam logic [4:0] S_RX    = 5'd4;
    localparam logic [4:0] S_RY    = 5'd5;
    localparam logic [4:0] S_EXEC  = 5'd6;
    localparam logic [4:0] S_WF    = 5'd7;
    localparam logic [4:0] S_ST    = 5'd8;
    localparam logic [4:0] S_LDRD  = 5'd9;
    localparam logic [4:0] S_LDWR  = 5'd10;
    localparam logic [4:0] S_BCD   = 5'd11;
    localparam logic [4:0] S_B0    = 5'd12;
    localparam logic [4:0] S_B1    = 5'd13;
    localparam logic [4:0] S_B2    = 5'd14;
    localparam logic [4:0] S_DRRD  = 5'd15;
    localparam logic [4:0] S_DRPX  = 5'd16;
    localparam logic [4:0] S_DONE  = 5'd17;

    // control and architectural registers
    logic [4:0]  state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] pc_reg, pc_next;
    logic [15:0] idx_reg, idx_next;
    logic [c8_pkg::SP_W-1:0] sp_reg, sp_next;
    logic [7:0]  dt_reg, dt_next;
    logic [7:0]  snd_reg, snd_next;
    logic [15:0] keys_reg, keys_next;
    logic        await_reg, await_next;
    logic        relv_reg, relv_next;
    logic [3:0]  relk_reg, relk_next;
    logic        drew_reg, drew_next;
    logic        halt_reg, halt_next;
    logic [5:0]  cfg_reg, cfg_next;
    logic        outv_reg, outv_next;

    // working registers
    logic [7:0]  hi_reg, hi_next;
    logic [15:0] op_reg, op_next;
    logic [7:0]  vx_reg, vx_next;
    logic [7:0]  vy_reg, vy_next;
    logic [7:0]  rnd_reg, rnd_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [2:0]  col_reg, col_next;
    logic        hit_reg, hit_next;
    logic        flag_reg, flag_next;
    logic [2:0]  stat_reg, stat_next;
    logic        pix_reg, pix_next;
    logic        chg_reg, chg_next;
    logic [7:0]  bval_reg, bval_next;
    logic [1:0]  bh_reg, bh_next;
    logic [3:0]  bt_reg, bt_next;
    logic [2:0]  ostat_reg, ostat_next;
    logic [14:0] odata_reg, odata_next;

    // main memory
    logic [7:0]    mem [c8_pkg::MEM_DEPTH];
    logic [7:0]    mem_rdata_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;

    // data register file, one read and one write port
    logic [7:0] v_reg [16];
    logic       v_we;
    logic [3:0] v_wa, v_ra;
    logic [7:0] v_wd, v_rd;

    // return stack
    logic [AW-1:0] stk_reg [c8_pkg::STACK_DEPTH];
    logic          stk_we;
    logic [c8_pkg::SP_W-1:0] sp_m1;

    // screen rows with valid bits
    logic [c8_pkg::SCREEN_W-1:0] fb_row_reg [c8_pkg::SCREEN_H];
    logic [c8_pkg::SCREEN_H-1:0] fb_val_reg;
    logic                        fb_clr, fb_we;
    logic [c8_pkg::ROW_W-1:0]    fb_ra;
    logic [c8_pkg::SCREEN_W-1:0] fb_rd, fb_wd;

    // beat fields
    logic [2:0]    in_cmd;
    logic [3:0]    in_key;
    logic [AW-1:0] in_addr;
    logic [7:0]    in_wdata, in_rnd;
    logic          in_acc;

    // opcode fields
    logic [3:0]    op_x, op_y, op_n, op_hi;
    logic [7:0]    op_nn;
    logic [AW-1:0] op_nnn, pc_p2, pc_p4;

    // draw address helpers
    logic [c8_pkg::ROW_W:0]   ny_sum;
    logic [c8_pkg::COL_W:0]   nx_sum;
    logic [7:0]               ly_sum;
    logic [10:0]              lin_idx;
    logic [c8_pkg::ROW_W-1:0] px_row;
    logic [c8_pkg::COL_W-1:0] px_col;
    logic                     px_clip, px_bit;

    c8_pkg::alu_res_t alu_res;

    assign in_cmd   = s_tuser;
    assign in_key   = s_tdata[3:0];
    assign in_addr  = s_tdata[15:4];
    assign in_wdata = s_tdata[23:16];
    assign in_rnd   = s_tdata[31:24];
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign op_hi  = op_reg[15:12];
    assign op_x   = op_reg[11:8];
    assign op_y   = op_reg[7:4];
    assign op_n   = op_reg[3:0];
    assign op_nn  = op_reg[7:0];
    assign op_nnn = op_reg[11:0];
    assign pc_p2  = pc_reg + 12'd2;
    assign pc_p4  = pc_reg + 12'd4;
    assign sp_m1  = sp_reg - 1'b1;

    assign v_rd  = v_reg[v_ra];
    assign fb_rd = fb_val_reg[fb_ra] ? fb_row_reg[fb_ra] : '0;

    // draw pixel position for the current row and column
    assign ny_sum  = {1'b0, vy_reg[c8_pkg::ROW_W-1:0]} + {2'b00, cnt_reg};
    assign nx_sum  = {1'b0, vx_reg[c8_pkg::COL_W-1:0]} + {4'b0000, col_reg};
    assign ly_sum  = vy_reg + {4'b0000, cnt_reg};
    assign lin_idx = {ly_sum[c8_pkg::ROW_W-1:0], 6'b000000} + {3'b000, vx_reg}
                   + {8'b00000000, col_reg};
    assign px_row  = cfg_reg[c8_pkg::CFG_WRAP_LIN] ? lin_idx[10:6]
                                                   : ny_sum[c8_pkg::ROW_W-1:0];
    assign px_col  = cfg_reg[c8_pkg::CFG_WRAP_LIN] ? lin_idx[5:0]
                                                   : nx_sum[c8_pkg::COL_W-1:0];
    assign px_clip = !cfg_reg[c8_pkg::CFG_WRAP_LIN] && nx_sum[c8_pkg::COL_W];
    assign px_bit  = mem_rdata_reg[3'd7 - col_reg];

    c8_alu u_alu
    (
        .op        (op_n),
        .vx        (vx_reg),
        .vy        (vy_reg),
        .keep_flag (cfg_reg[c8_pkg::CFG_KEEP_FLAG]),
        .shift_vx  (cfg_reg[c8_pkg::CFG_SHIFT_VX]),
        .res       (alu_res)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        pc_next    = pc_reg;
        idx_next   = idx_reg;
        sp_next    = sp_reg;
        dt_next    = dt_reg;
        snd_next   = snd_reg;
        keys_next  = keys_reg;
        await_next = await_reg;
        relv_next  = relv_reg;
        relk_next  = relk_reg;
        drew_next  = drew_reg;
        halt_next  = halt_reg;
        cfg_next   = cfg_reg;
        outv_next  = outv_reg;
        hi_next    = hi_reg;
        op_next    = op_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        rnd_next   = rnd_reg;
        cnt_next   = cnt_reg;
        col_next   = col_reg;
        hit_next   = hit_reg;
        flag_next  = flag_reg;
        stat_next  = stat_reg;
        pix_next   = pix_reg;
        chg_next   = chg_reg;
        bval_next  = bval_reg;
        bh_next    = bh_reg;
        bt_next    = bt_reg;
        ostat_next = ostat_reg;
        odata_next = odata_reg;
        mem_we     = 1'b0;
        mem_waddr  = clr_reg;
        mem_wdata  = 8'h00;
        mem_re     = 1'b0;
        mem_raddr  = pc_reg;
        v_we       = 1'b0;
        v_wa       = op_x;
        v_wd       = 8'h00;
        v_ra       = op_x;
        stk_we     = 1'b0;
        fb_clr     = 1'b0;
        fb_we      = 1'b0;
        fb_ra      = in_addr[10:6];
        fb_wd      = fb_rd;

        // configuration writes
        if (cfg_valid)
        begin
            case (cfg_index)
                c8_pkg::CFG_KEEP_FLAG:  cfg_next[c8_pkg::CFG_KEEP_FLAG]  = cfg_data;
                c8_pkg::CFG_SHIFT_VX:   cfg_next[c8_pkg::CFG_SHIFT_VX]   = cfg_data;
                c8_pkg::CFG_JUMP_VX:    cfg_next[c8_pkg::CFG_JUMP_VX]    = cfg_data;
                c8_pkg::CFG_WRAP_LIN:   cfg_next[c8_pkg::CFG_WRAP_LIN]   = cfg_data;
                c8_pkg::CFG_NO_DSPWAIT: cfg_next[c8_pkg::CFG_NO_DSPWAIT] = cfg_data;
                c8_pkg::CFG_IDX_KEEP:   cfg_next[c8_pkg::CFG_IDX_KEEP]   = cfg_data;
                default: ;
            endcase
        end

        // output register drains
        if (outv_reg && m_tready)
        begin
            outv_next = 1'b0;
        end

        case (state_reg)
            // zero the memory after reset
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            // take a beat; non-step commands finish here
            S_IDLE:
            begin
                mem_re = 1'b1;
                if (in_acc)
                begin
                    chg_next  = 1'b0;
                    pix_next  = 1'b0;
                    stat_next = c8_pkg::STAT_OTHER;
                    rnd_next  = in_rnd;
                    state_next = S_DONE;
                    case (in_cmd)
                        c8_pkg::CMD_STEP:
                        begin
                            if (halt_reg)
                            begin
                                stat_next = c8_pkg::STAT_FAULT;
                            end
                            else
                            begin
                                state_next = S_F1;
                            end
                        end
                        c8_pkg::CMD_FRAME:
                        begin
                            drew_next = 1'b0;
                            if (dt_reg != 8'h00) dt_next = dt_reg - 8'd1;
                            if (snd_reg != 8'h00) snd_next = snd_reg - 8'd1;
                        end
                        c8_pkg::CMD_KEYDN:
                        begin
                            keys_next[in_key] = 1'b1;
                        end
                        c8_pkg::CMD_KEYUP:
                        begin
                            if (await_reg)
                            begin
                                relv_next = 1'b1;
                                relk_next = in_key;
                            end
                            keys_next[in_key] = 1'b0;
                        end
                        c8_pkg::CMD_WRMEM:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = in_addr;
                            mem_wdata = in_wdata;
                        end
                        c8_pkg::CMD_PIXEL:
                        begin
                            pix_next = fb_rd[in_addr[5:0]];
                        end
                        default: ;
                    endcase
                end
            end
            // fetch high byte, issue low byte
            S_F1:
            begin
                hi_next    = mem_rdata_reg;
                mem_re     = 1'b1;
                mem_raddr  = pc_reg + 12'd1;
                state_next = S_F2;
            end
            S_F2:
            begin
                op_next    = {hi_reg, mem_rdata_reg};
                state_next = S_RX;
            end
            // operand reads through the single register port
            S_RX:
            begin
                v_ra = (op_hi == c8_pkg::OPG_JPV && !cfg_reg[c8_pkg::CFG_JUMP_VX]) ? 4'h0
                                                                               : op_x;
                vx_next    = v_rd;
                state_next = S_RY;
            end
            S_RY:
            begin
                v_ra       = op_y;
                vy_next    = v_rd;
                state_next = S_EXEC;
            end
            // execute
            S_EXEC:
            begin
                pc_next    = pc_p2;
                stat_next  = c8_pkg::STAT_EXEC;
                state_next = S_DONE;
                case (op_hi)
                    c8_pkg::OPG_SYS:
                    begin
                        if (op_reg == {c8_pkg::OPG_SYS, c8_pkg::OPS_CLS})
                        begin
                            fb_clr   = 1'b1;
                            chg_next = 1'b1;
                        end
                        else if (op_reg == {c8_pkg::OPG_SYS, c8_pkg::OPS_RET} &&
                                 sp_reg != '0)
                        begin
                            sp_next = sp_m1;
                            pc_next = stk_reg[sp_m1[c8_pkg::SIDX_W-1:0]];
                        end
                        else
                        begin
                            halt_next = 1'b1;
                            pc_next   = pc_reg;
                            stat_next = c8_pkg::STAT_FAULT;
                        end
                    end
                    c8_pkg::OPG_JP:
                    begin
                        pc_next = op_nnn;
                    end
                    c8_pkg::OPG_CALL:
                    begin
                        if (sp_reg == c8_pkg::SP_W'(c8_pkg::STACK_DEPTH))
                        begin
                            halt_next = 1'b1;
                            pc_next   = pc_reg;
                            stat_next = c8_pkg::STAT_FAULT;
                        end
                        else
                        begin
                            stk_we  = 1'b1;
                            sp_next = sp_reg + 1'b1;
                            pc_next = op_nnn;
                        end
                    end
                    c8_pkg::OPG_SE:
                    begin
                        if (vx_reg == op_nn) pc_next = pc_p4;
                    end
                    c8_pkg::OPG_SNE:
                    begin
                        if (vx_reg != op_nn) pc_next = pc_p4;
                    end
                    c8_pkg::OPG_SER, c8_pkg::OPG_SNER:
                    begin
                        if (op_n != 4'h0)
                        begin
                            halt_next = 1'b1;
                            pc_next   = pc_reg;
                            stat_next = c8_pkg::STAT_FAULT;
                        end
                        else if ((vx_reg == vy_reg) == (op_hi == c8_pkg::OPG_SER))
                        begin
                            pc_next = pc_p4;
                        end
                    end
                    c8_pkg::OPG_LD:
                    begin
                        v_we = 1'b1;
                        v_wd = op_nn;
                    end
                    c8_pkg::OPG_ADD:
                    begin
                        v_we = 1'b1;
                        v_wd = vx_reg + op_nn;
                    end
                    c8_pkg::OPG_ALU:
                    begin
                        if (alu_res.legal)
                        begin
                            v_we      = 1'b1;
                            v_wd      = alu_res.value;
                            flag_next = alu_res.flag;
                            if (alu_res.set_vf) state_next = S_WF;
                        end
                        else
                        begin
                            halt_next = 1'b1;
                            pc_next   = pc_reg;
                            stat_next = c8_pkg::STAT_FAULT;
                        end
                    end
                    c8_pkg::OPG_LDI:
                    begin
                        idx_next = {4'h0, op_nnn};
                    end
                    c8_pkg::OPG_JPV:
                    begin
                        pc_next = {4'h0, vx_reg} + op_nnn;
                    end
                    c8_pkg::OPG_RND:
                    begin
                        v_we = 1'b1;
                        v_wd = rnd_reg & op_nn;
                    end
                    c8_pkg::OPG_DRW:
                    begin
                        if (!cfg_reg[c8_pkg::CFG_NO_DSPWAIT] && drew_reg)
                        begin
                            pc_next   = pc_reg;
                            stat_next = c8_pkg::STAT_WAIT_DSP;
                        end
                        else
                        begin
                            cnt_next   = 4'h0;
                            hit_next   = 1'b0;
                            state_next = S_DRRD;
                        end
                    end
                    c8_pkg::OPG_KEY:
                    begin
                        if (op_nn == c8_pkg::OPK_SKP)
                        begin
                            if (keys_reg[vx_reg[3:0]]) pc_next = pc_p4;
                        end
                        else if (op_nn == c8_pkg::OPK_SKNP)
                        begin
                            if (!keys_reg[vx_reg[3:0]]) pc_next = pc_p4;
                        end
                        else
                        begin
                            halt_next = 1'b1;
                            pc_next   = pc_reg;
                            stat_next = c8_pkg::STAT_FAULT;
                        end
                    end
                    default:
                    begin
                        case (op_nn)
                            c8_pkg::OPF_GET_DT:
                            begin
                                v_we = 1'b1;
                                v_wd = dt_reg;
                            end
                            c8_pkg::OPF_WAIT_KEY:
                            begin
                                if (!await_reg || !relv_reg)
                                begin
                                    await_next = 1'b1;
                                    pc_next    = pc_reg;
                                    stat_next  = c8_pkg::STAT_WAIT_KEY;
                                end
                                else
                                begin
                                    await_next = 1'b0;
                                    relv_next  = 1'b0;
                                    v_we       = 1'b1;
                                    v_wd       = {4'h0, relk_reg};
                                end
                            end
                            c8_pkg::OPF_SET_DT: dt_next  = vx_reg;
                            c8_pkg::OPF_SET_ST: snd_next = vx_reg;
                            c8_pkg::OPF_ADD_I:  idx_next = idx_reg + {8'h00, vx_reg};
                            c8_pkg::OPF_FONT:
                                idx_next = {6'b0, vx_reg, 2'b00} + {8'h00, vx_reg};
                            c8_pkg::OPF_BCD:
                            begin
                                bval_next  = vx_reg;
                                bh_next    = 2'd0;
                                bt_next    = 4'd0;
                                state_next = S_BCD;
                            end
                            c8_pkg::OPF_STORE:
                            begin
                                cnt_next   = 4'h0;
                                state_next = S_ST;
                            end
                            c8_pkg::OPF_LOAD:
                            begin
                                cnt_next   = 4'h0;
                                state_next = S_LDRD;
                            end
                            default:
                            begin
                                halt_next = 1'b1;
                                pc_next   = pc_reg;
                                stat_next = c8_pkg::STAT_FAULT;
                            end
                        endcase
                    end
                endcase
            end
            // flag register write after the result
            S_WF:
            begin
                v_we       = 1'b1;
                v_wa       = 4'hF;
                v_wd       = {7'b0, flag_reg};
                state_next = S_DONE;
            end
            // register store, one register a cycle
            S_ST:
            begin
                v_ra      = cnt_reg;
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0] + {8'h00, cnt_reg};
                mem_wdata = v_rd;
                cnt_next  = cnt_reg + 4'h1;
                if (cnt_reg == op_x)
                begin
                    if (!cfg_reg[c8_pkg::CFG_IDX_KEEP])
                        idx_next = idx_reg + {12'h000, op_x} + 16'd1;
                    state_next = S_DONE;
                end
            end
            // register load, read then write
            S_LDRD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg[AW-1:0] + {8'h00, cnt_reg};
                state_next = S_LDWR;
            end
            S_LDWR:
            begin
                v_we       = 1'b1;
                v_wa       = cnt_reg;
                v_wd       = mem_rdata_reg;
                cnt_next   = cnt_reg + 4'h1;
                state_next = S_LDRD;
                if (cnt_reg == op_x)
                begin
                    if (!cfg_reg[c8_pkg::CFG_IDX_KEEP])
                        idx_next = idx_reg + {12'h000, op_x} + 16'd1;
                    state_next = S_DONE;
                end
            end
            // decimal digits by repeated subtraction
            S_BCD:
            begin
                if (bval_reg >= c8_pkg::BCD_HUNDRED)
                begin
                    bval_next = bval_reg - c8_pkg::BCD_HUNDRED;
                    bh_next   = bh_reg + 2'd1;
                end
                else if (bval_reg >= c8_pkg::BCD_TEN)
                begin
                    bval_next = bval_reg - c8_pkg::BCD_TEN;
                    bt_next   = bt_reg + 4'd1;
                end
                else
                begin
                    state_next = S_B0;
                end
            end
            S_B0:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[AW-1:0];
                mem_wdata  = {6'b0, bh_reg};
                state_next = S_B1;
            end
            S_B1:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[AW-1:0] + 12'd1;
                mem_wdata  = {4'h0, bt_reg};
                state_next = S_B2;
            end
            S_B2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[AW-1:0] + 12'd2;
                mem_wdata  = bval_reg;
                state_next = S_DONE;
            end
            // sprite row fetch or end of draw
            S_DRRD:
            begin
                if (cnt_reg == op_n ||
                    (!cfg_reg[c8_pkg::CFG_WRAP_LIN] && ny_sum[c8_pkg::ROW_W]))
                begin
                    flag_next  = hit_reg;
                    drew_next  = 1'b1;
                    chg_next   = 1'b1;
                    state_next = S_WF;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_reg[AW-1:0] + {8'h00, cnt_reg};
                    col_next   = 3'd0;
                    state_next = S_DRPX;
                end
            end
            // one sprite pixel a cycle
            S_DRPX:
            begin
                fb_ra = px_row;
                fb_wd = fb_rd ^ (64'd1 << px_col);
                if (px_bit && !px_clip)
                begin
                    fb_we = 1'b1;
                    if (fb_rd[px_col]) hit_next = 1'b1;
                end
                col_next = col_reg + 3'd1;
                if (col_reg == 3'd7)
                begin
                    cnt_next   = cnt_reg + 4'h1;
                    state_next = S_DRRD;
                end
            end
            // hand the result to the output register
            S_DONE:
            begin
                if (!outv_reg || m_tready)
                begin
                    outv_next  = 1'b1;
                    ostat_next = stat_reg;
                    odata_next = {chg_reg, (snd_reg != 8'h00), pc_reg, pix_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            pc_reg    <= c8_pkg::ENTRY_ADDR;
            idx_reg   <= '0;
            sp_reg    <= '0;
            dt_reg    <= '0;
            snd_reg   <= '0;
            keys_reg  <= '0;
            await_reg <= 1'b0;
            relv_reg  <= 1'b0;
            relk_reg  <= '0;
            drew_reg  <= 1'b0;
            halt_reg  <= 1'b0;
            cfg_reg   <= '0;
            outv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pc_reg    <= pc_next;
            idx_reg   <= idx_next;
            sp_reg    <= sp_next;
            dt_reg    <= dt_next;
            snd_reg   <= snd_next;
            keys_reg  <= keys_next;
            await_reg <= await_next;
            relv_reg  <= relv_next;
            relk_reg  <= relk_next;
            drew_reg  <= drew_next;
            halt_reg  <= halt_next;
            cfg_reg   <= cfg_next;
            outv_reg  <= outv_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        hi_reg    <= hi_next;
        op_reg    <= op_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        rnd_reg   <= rnd_next;
        cnt_reg   <= cnt_next;
        col_reg   <= col_next;
        hit_reg   <= hit_next;
        flag_reg  <= flag_next;
        stat_reg  <= stat_next;
        pix_reg   <= pix_next;
        chg_reg   <= chg_next;
        bval_reg  <= bval_next;
        bh_reg    <= bh_next;
        bt_reg    <= bt_next;
        ostat_reg <= ostat_next;
        odata_reg <= odata_next;
        if (stk_we)
        begin
            stk_reg[sp_reg[c8_pkg::SIDX_W-1:0]] <= pc_p2;
        end
    end

    // main memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                v_reg[i] <= '0;
            end
        end
        else if (v_we)
        begin
            v_reg[v_wa] <= v_wd;
        end
    end

    // screen row valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_val_reg <= '0;
        end
        else if (fb_clr)
        begin
            fb_val_reg <= '0;
        end
        else if (fb_we)
        begin
            fb_val_reg[fb_ra] <= 1'b1;
        end
    end

    // screen row data
    always_ff @(posedge clk)
    begin
        if (fb_we)
        begin
            fb_row_reg[fb_ra] <= fb_wd;
        end
    end

    assign m_tvalid = outv_reg;
    assign m_tuser  = ostat_reg;
    assign m_tdata  = {1'b0, odata_reg};

endmodule
